// ===== src/tws_pkg.sv =====
package tws_pkg;

  // default ring depth
  localparam int unsigned DefaultSlots = 5;

  // input mode codes
  localparam logic [1:0] MODE_SAT = 2'd0;
  localparam logic [1:0] MODE_EXP = 2'd1;
  localparam logic [1:0] MODE_SUM = 2'd2;

  // result and slot kind codes
  localparam logic [1:0] KIND_SAT   = 2'd0;
  localparam logic [1:0] KIND_EXP   = 2'd1;
  localparam logic [1:0] KIND_SUM   = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  // starting extremes, tenths
  localparam logic signed [15:0] INIT_MAX_TEMP = -16'sd500;
  localparam logic signed [15:0] INIT_MIN_TEMP = 16'sd2120;
  localparam logic [15:0]        INIT_MAX_VOLT = 16'd0;
  localparam logic [15:0]        INIT_MIN_VOLT = 16'd1000;

  // one input item
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] temperature;
    logic [15:0]        voltage;
    logic [15:0]        radiation_count;
    logic [15:0]        latchup_count;
  } item_t;

  // one result item
  typedef struct packed {
    logic [1:0]         kind;
    logic               last;
    logic signed [15:0] temp_first;
    logic signed [15:0] temp_second;
    logic [15:0]        volt_first;
    logic [15:0]        volt_second;
    logic [15:0]        count_first;
    logic [15:0]        count_second;
    logic [2:0]         satellite_records;
    logic [2:0]         experiment_records;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic store;
    logic clear;
    logic rd_en;
    logic emit_sum;
  } cmd_t;

endpackage

// ===== src/tws_ctrl.sv =====
module tws_ctrl #(
  parameter int unsigned SLOTS    = tws_pkg::DefaultSlots,
  parameter int unsigned SlotIdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic [1:0]          mode_i,
  output logic                busy,
  output tws_pkg::cmd_t       cmd_o,
  output logic [SlotIdxW-1:0] rd_idx_o
);
  import tws_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_FLUSH = 4'b0100,
    S_SUM   = 4'b1000
  } state_e;

  localparam logic [SlotIdxW-1:0] LastIdx = SlotIdxW'(SLOTS - 1);

  state_e              state_q, state_d;
  logic [SlotIdxW-1:0] idx_q, idx_d;
  logic                accept;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (mode_i == MODE_SAT || mode_i == MODE_EXP) begin
            cmd_o.store = 1'b1;
          end else if (mode_i == MODE_SUM) begin
            cmd_o.clear = 1'b1;
            idx_d       = '0;
            state_d     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (idx_q == LastIdx) begin
          state_d = S_FLUSH;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_FLUSH: begin
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.emit_sum = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rd_idx_o = idx_q;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ===== src/tws_dpath.sv =====
module tws_dpath #(
  parameter int unsigned SLOTS    = tws_pkg::DefaultSlots,
  parameter int unsigned SlotIdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tws_pkg::cmd_t       cmd_i,
  input  logic [SlotIdxW-1:0] rd_idx_i,
  input  tws_pkg::item_t      item_i,
  output logic                result_valid_o,
  output tws_pkg::result_t    result_o
);
  import tws_pkg::*;

  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam logic [SlotIdxW-1:0] LastIdx = SlotIdxW'(SLOTS - 1);

  // slot storage: kinds reset to empty, words only valid once written
  logic [1:0]          slot_kind_q [SLOTS];
  logic [31:0]         slot_mem [SLOTS];
  logic [SlotIdxW-1:0] wr_slot_q;
  logic [31:0]         wr_word;

  // registered read port
  logic                rd_vld_q;
  logic [1:0]          kind_rd_q;
  logic [31:0]         word_rd_q;

  // running summary
  logic signed [15:0]  max_temp_q, min_temp_q;
  logic [15:0]         max_volt_q, min_volt_q;
  logic [15:0]         tot_rad_q, tot_lat_q;
  logic [CntW-1:0]     sat_cnt_q, exp_cnt_q;

  logic signed [15:0]  rec_temp;
  logic [15:0]         rec_volt;
  logic                rec_sat, rec_exp;

  result_t             result_d;
  logic                result_valid_d;

  assign wr_word = (item_i.mode == MODE_SAT)
                 ? {item_i.temperature, item_i.voltage}
                 : {item_i.radiation_count, item_i.latchup_count};

  // slot kinds and write pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_kind_q[i] <= KIND_EMPTY;
      end
      wr_slot_q <= '0;
    end else if (cmd_i.store) begin
      slot_kind_q[wr_slot_q] <= item_i.mode;
      wr_slot_q <= (wr_slot_q == LastIdx) ? '0 : wr_slot_q + 1'b1;
    end
  end

  // record word memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      slot_mem[wr_slot_q] <= wr_word;
    end
    if (cmd_i.rd_en) begin
      word_rd_q <= slot_mem[rd_idx_i];
    end
  end

  // read strobe and kind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      kind_rd_q <= KIND_EMPTY;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.rd_en) begin
        kind_rd_q <= slot_kind_q[rd_idx_i];
      end
    end
  end

  assign rec_temp = signed'(word_rd_q[31:16]);
  assign rec_volt = word_rd_q[15:0];
  assign rec_sat  = rd_vld_q && (kind_rd_q == KIND_SAT);
  assign rec_exp  = rd_vld_q && (kind_rd_q == KIND_EXP);

  // summary accumulation
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      max_temp_q <= INIT_MAX_TEMP;
      min_temp_q <= INIT_MIN_TEMP;
      max_volt_q <= INIT_MAX_VOLT;
      min_volt_q <= INIT_MIN_VOLT;
      tot_rad_q  <= '0;
      tot_lat_q  <= '0;
      sat_cnt_q  <= '0;
      exp_cnt_q  <= '0;
    end else if (rec_sat) begin
      if (rec_temp > max_temp_q) max_temp_q <= rec_temp;
      if (rec_temp < min_temp_q) min_temp_q <= rec_temp;
      if (rec_volt > max_volt_q) max_volt_q <= rec_volt;
      if (rec_volt < min_volt_q) min_volt_q <= rec_volt;
      sat_cnt_q <= sat_cnt_q + 1'b1;
    end else if (rec_exp) begin
      tot_rad_q <= tot_rad_q + word_rd_q[31:16];
      tot_lat_q <= tot_lat_q + word_rd_q[15:0];
      exp_cnt_q <= exp_cnt_q + 1'b1;
    end
  end

  // result selection
  always_comb begin
    result_d       = '0;
    result_valid_d = 1'b0;
    if (cmd_i.emit_sum) begin
      result_valid_d              = 1'b1;
      result_d.kind               = KIND_SUM;
      result_d.last               = 1'b1;
      result_d.temp_first         = max_temp_q;
      result_d.temp_second        = min_temp_q;
      result_d.volt_first         = max_volt_q;
      result_d.volt_second        = min_volt_q;
      result_d.count_first        = tot_rad_q;
      result_d.count_second       = tot_lat_q;
      result_d.satellite_records  = 3'(sat_cnt_q);
      result_d.experiment_records = 3'(exp_cnt_q);
    end else if (rec_sat) begin
      result_valid_d      = 1'b1;
      result_d.kind       = KIND_SAT;
      result_d.temp_first = rec_temp;
      result_d.volt_first = rec_volt;
    end else if (rec_exp) begin
      result_valid_d        = 1'b1;
      result_d.kind         = KIND_EXP;
      result_d.count_first  = word_rd_q[31:16];
      result_d.count_second = word_rd_q[15:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= result_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_valid_d) begin
      result_o <= result_d;
    end
  end

endmodule

// ===== src/telemetry_window_summary.sv =====
// Telemetry window summary: a ring of SLOTS tagged record slots.
// Input channel: an item transfers at a rising edge with start high and busy
// low. Mode 0 stores a satellite record (temperature, voltage), mode 1 an
// experiment record (radiation, latchup count) at the write pointer, which
// wraps after the last slot; mode 3 is ignored. Both give no result, so busy
// stays low.
// Mode 2 requests a summary: busy rises while the controller walks the
// slots through the registered read port of the slot memory, one slot per
// cycle. Each non-empty slot comes out in slot order, then one summary item
// with last set. Each record passes the read-port registers and the output
// register; the summary follows the last record, once busy has fallen again.
// Output channel: result_valid_o marks each result for exactly one cycle;
// the receiver must take it then, there is no back-pressure.
// Reset marks every slot empty and returns the write pointer to slot 0.
module telemetry_window_summary #(
  parameter int unsigned SLOTS    = tws_pkg::DefaultSlots,
  parameter int unsigned SlotIdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  tws_pkg::item_t   item_i,
  output logic             result_valid_o,
  output tws_pkg::result_t result_o
);
  import tws_pkg::*;

  cmd_t                cmd;
  logic [SlotIdxW-1:0] rd_idx;

  // sequencer
  tws_ctrl #(
    .SLOTS    (SLOTS),
    .SlotIdxW (SlotIdxW)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .mode_i   (item_i.mode),
    .busy     (busy),
    .cmd_o    (cmd),
    .rd_idx_o (rd_idx)
  );

  // slot storage and summary datapath
  tws_dpath #(
    .SLOTS    (SLOTS),
    .SlotIdxW (SlotIdxW)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .rd_idx_i       (rd_idx),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ===== src/tws_checker.sv =====
module tws_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input tws_pkg::item_t   item_i,
  input logic             result_valid_o,
  input tws_pkg::result_t result_o
);
  import tws_pkg::*;

  // a summary request occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.mode == MODE_SUM |=> busy)
    else $error("summary transfer did not raise busy");

  // stores and ignored items leave the block idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.mode != MODE_SUM |=> !busy)
    else $error("store transfer left the block busy");

  // records come out only during a walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.kind != KIND_SUM |-> busy)
    else $error("record transfer outside a summary walk");

  // the summary closes the walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.kind == KIND_SUM |-> result_o.last && !busy)
    else $error("summary transfer not last or block still busy");

endmodule

bind telemetry_window_summary tws_checker u_tws_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .item_i         (item_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

// ===== bench/telemetry_window_summary_test.sv =====
module telemetry_window_summary_test;
  import tws_pkg::*;

  localparam int unsigned RingSlots = DefaultSlots;
  localparam int unsigned RandomItems = 400;
  localparam int unsigned MaxGap = 12;
  localparam int unsigned TailCycles = RingSlots + 8;
  localparam int unsigned CycleLimit = 200000;
  // mode 3 has no code in the package, the block ignores it
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    item_t   item;
    bit      drain;
    bit      typed;
    result_t summary;
  } stim_row_t;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   item_i;
  logic    result_valid_o;
  result_t result_o;

  // predictor state: tagged ring and write pointer
  logic [1:0]  ring_kind [RingSlots];
  logic [15:0] ring_word_a [RingSlots];
  logic [15:0] ring_word_b [RingSlots];
  int unsigned ring_wr_ptr;

  result_t     expected_reports[$];
  stim_row_t   directed_rows[$];
  int unsigned failures;
  int unsigned cycle_count;

  telemetry_window_summary #(
    .SLOTS(RingSlots)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ring model: stores update a slot, a summary walks the ring
  task automatic apply_telemetry(input item_t it);
    logic signed [15:0] max_t;
    logic signed [15:0] min_t;
    logic [15:0]        max_v;
    logic [15:0]        min_v;
    logic [15:0]        tot_r;
    logic [15:0]        tot_l;
    logic [2:0]         sat_n;
    logic [2:0]         exp_n;
    result_t            r;
    if (it.mode == MODE_SAT || it.mode == MODE_EXP) begin
      ring_kind[ring_wr_ptr] = it.mode;
      ring_word_a[ring_wr_ptr] = (it.mode == MODE_SAT) ? it.temperature : it.radiation_count;
      ring_word_b[ring_wr_ptr] = (it.mode == MODE_SAT) ? it.voltage : it.latchup_count;
      ring_wr_ptr = (ring_wr_ptr == RingSlots - 1) ? 0 : ring_wr_ptr + 1;
    end else if (it.mode == MODE_SUM) begin
      max_t = INIT_MAX_TEMP;
      min_t = INIT_MIN_TEMP;
      max_v = INIT_MAX_VOLT;
      min_v = INIT_MIN_VOLT;
      tot_r = '0;
      tot_l = '0;
      sat_n = '0;
      exp_n = '0;
      for (int i = 0; i < RingSlots; i++) begin
        r = '0;
        if (ring_kind[i] == KIND_SAT) begin
          r.kind = KIND_SAT;
          r.temp_first = ring_word_a[i];
          r.volt_first = ring_word_b[i];
          expected_reports.push_back(r);
          sat_n++;
          if (r.temp_first > max_t) max_t = r.temp_first;
          if (r.temp_first < min_t) min_t = r.temp_first;
          if (r.volt_first > max_v) max_v = r.volt_first;
          if (r.volt_first < min_v) min_v = r.volt_first;
        end else if (ring_kind[i] == KIND_EXP) begin
          r.kind = KIND_EXP;
          r.count_first = ring_word_a[i];
          r.count_second = ring_word_b[i];
          expected_reports.push_back(r);
          exp_n++;
          tot_r = tot_r + ring_word_a[i];
          tot_l = tot_l + ring_word_b[i];
        end
      end
      expected_reports.push_back(summary_word(max_t, min_t, max_v, min_v,
                                              tot_r, tot_l, sat_n, exp_n));
    end
  endtask

  function automatic result_t summary_word(logic signed [15:0] t_hi, logic signed [15:0] t_lo,
                                           logic [15:0] v_hi, logic [15:0] v_lo,
                                           logic [15:0] c_a, logic [15:0] c_b,
                                           logic [2:0] sats, logic [2:0] exps);
    result_t r;
    r.kind = KIND_SUM;
    r.last = 1'b1;
    r.temp_first = t_hi;
    r.temp_second = t_lo;
    r.volt_first = v_hi;
    r.volt_second = v_lo;
    r.count_first = c_a;
    r.count_second = c_b;
    r.satellite_records = sats;
    r.experiment_records = exps;
    return r;
  endfunction

  function automatic item_t make_item(logic [1:0] mode, logic [15:0] a, logic [15:0] b);
    item_t it;
    it = '0;
    it.mode = mode;
    if (mode == MODE_SAT) begin
      it.temperature = a;
      it.voltage = b;
    end else if (mode == MODE_EXP) begin
      it.radiation_count = a;
      it.latchup_count = b;
    end else if (mode == MODE_UNUSED) begin
      it = '1;
      it.temperature = a;
      it.voltage = b;
    end
    return it;
  endfunction

  task automatic add_row(input item_t it, input bit drain = 1'b0, input bit typed = 1'b0,
                         input result_t sum = '0);
    stim_row_t row;
    row.item = it;
    row.drain = drain;
    row.typed = typed;
    row.summary = sum;
    directed_rows.push_back(row);
  endtask

  // random 16-bit value, biased toward edges and a window of interest
  function automatic logic [15:0] pick16(logic [15:0] base, int unsigned span);
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      3: return 16'h8000 | 16'($urandom_range(0, 3));
      default: return base + 16'($urandom_range(0, span));
    endcase
  endfunction

  // one transfer: optional gap or drain, then hold start until accepted
  task automatic send_item(input item_t it, input int unsigned gap, input bit drain,
                           input bit typed, input result_t sum);
    if (gap > 0 || (drain && expected_reports.size() != 0)) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
      while (drain && expected_reports.size() != 0) @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    apply_telemetry(it);
    if (typed) expected_reports[expected_reports.size() - 1] = sum;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      failures++;
    end
  endtask

  // result monitor: each strobed result against the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      if (expected_reports.size() == 0) begin
        $error("result with no expectation waiting, kind %0d", result_o.kind);
        failures++;
      end else begin
        want = expected_reports.pop_front();
        check_field("kind", want.kind, result_o.kind);
        check_field("last", want.last, result_o.last);
        check_field("temp_first", want.temp_first, result_o.temp_first);
        check_field("temp_second", want.temp_second, result_o.temp_second);
        check_field("volt_first", want.volt_first, result_o.volt_first);
        check_field("volt_second", want.volt_second, result_o.volt_second);
        check_field("count_first", want.count_first, result_o.count_first);
        check_field("count_second", want.count_second, result_o.count_second);
        check_field("satellite_records", want.satellite_records,
                    result_o.satellite_records);
        check_field("experiment_records", want.experiment_records,
                    result_o.experiment_records);
      end
    end
  end

  // stimulus
  initial begin
    item_t       it;
    int unsigned sent;
    int unsigned pick;
    int unsigned gap;
    bit          burst;
    result_t     empty_sum;

    failures = 0;
    cycle_count = 0;
    ring_wr_ptr = 0;
    for (int i = 0; i < RingSlots; i++) begin
      ring_kind[i] = KIND_EMPTY;
      ring_word_a[i] = '0;
      ring_word_b[i] = '0;
    end
    rst_ni <= 1'b0;
    start <= 1'b0;
    item_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows: empty ring, ignored mode, extremes, wrap, no satellites
    empty_sum = summary_word(INIT_MAX_TEMP, INIT_MIN_TEMP, INIT_MAX_VOLT, INIT_MIN_VOLT,
                             16'd0, 16'd0, 3'd0, 3'd0);
    add_row(make_item(MODE_SUM, 16'h0000, 16'h0000), 1'b0, 1'b1, empty_sum);
    add_row(make_item(MODE_UNUSED, 16'hFFFF, 16'hFFFF));
    add_row(make_item(MODE_SUM, 16'hFFFF, 16'hFFFF), 1'b0, 1'b1, empty_sum);
    add_row(make_item(MODE_SAT, 16'h7FFF, 16'hFFFF));
    add_row(make_item(MODE_SAT, 16'h8000, 16'h0000));
    add_row(make_item(MODE_EXP, 16'hFFFF, 16'hFFFF));
    add_row(make_item(MODE_EXP, 16'h0001, 16'h0001));
    add_row(make_item(MODE_EXP, 16'h0000, 16'h0000));
    add_row(make_item(MODE_SUM, 16'h0000, 16'h0000), 1'b0, 1'b1,
            summary_word(16'sh7FFF, -16'sh8000, 16'hFFFF, 16'h0000,
                         16'd0, 16'd0, 3'd2, 3'd3));
    add_row(make_item(MODE_SAT, 16'h0000, 16'h0000), 1'b1);
    add_row(make_item(MODE_SUM, 16'h0000, 16'h0000));
    repeat (RingSlots) add_row(make_item(MODE_EXP, 16'hFFFF, 16'h8000));
    add_row(make_item(MODE_SUM, 16'h0000, 16'h0000), 1'b0, 1'b1,
            summary_word(INIT_MAX_TEMP, INIT_MIN_TEMP, INIT_MAX_VOLT, INIT_MIN_VOLT,
                         16'd65531, 16'd32768, 3'd0, 3'd5));
    add_row(make_item(MODE_UNUSED, 16'h5A5A, 16'hA5A5));
    add_row(make_item(MODE_SAT, 16'd100, 16'd50));
    add_row(make_item(MODE_SAT, -16'sd501, 16'd999));
    add_row(make_item(MODE_SAT, 16'sd2121, 16'd1001));
    add_row(make_item(MODE_SAT, INIT_MAX_TEMP, INIT_MIN_VOLT));
    add_row(make_item(MODE_SAT, INIT_MIN_TEMP, 16'd0));
    add_row(make_item(MODE_SUM, 16'h0000, 16'h0000));

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, $urandom_range(0, MaxGap), directed_rows[i].drain,
                directed_rows[i].typed, directed_rows[i].summary);

    // random items, mostly stores with summaries in between
    sent = 0;
    burst = 1'b0;
    while (sent < RandomItems) begin
      it.temperature = pick16(-16'sd700, 3200);
      it.voltage = pick16(16'd0, 1500);
      it.radiation_count = pick16(16'd0, 20000);
      it.latchup_count = pick16(16'd0, 20000);
      pick = $urandom_range(0, 99);
      if (pick < 38) it.mode = MODE_SAT;
      else if (pick < 76) it.mode = MODE_EXP;
      else if (pick < 94) it.mode = MODE_SUM;
      else it.mode = MODE_UNUSED;
      if ($urandom_range(0, 31) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, MaxGap);
      send_item(it, gap, $urandom_range(0, 49) == 0, 1'b0, '0);
      if (it.mode != MODE_UNUSED) sent++;
    end
    start <= 1'b0;

    // drain and let the block settle
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (expected_reports.size() != 0) failures++;
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
